>>> hdl/abed_pkg.sv
// Package with the widths, fixed-point constants and sequencer codes of the band envelope beat detector.
package abed_pkg;

	localparam int LEVEL_BITS = 16;
	localparam int ENV_W      = LEVEL_BITS + 8;
	localparam int BEAT_W     = LEVEL_BITS + 1;
	localparam int GAIN_W     = 16;
	localparam int NUM_BANDS  = 3;
	localparam int BAND_W     = 2;

	// Gain is applied as amp_gain / 5120, which is a shift by ten and a divide by five.
	localparam int GAIN_SHIFT = 10;
	localparam int GAIN_DIV   = 5;
	localparam int GAIN_HALF  = (GAIN_DIV << GAIN_SHIFT) / 2;
	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(GAIN_DIV << GAIN_SHIFT);

	// Dividend widths of the two divide-by-constant steps.
	localparam int T10_W = ENV_W + 4;
	localparam int P_W   = ENV_W + GAIN_W;
	localparam int U_W   = P_W - GAIN_SHIFT;

	// Reciprocals: q = (x * M) >> K with M = ceil(2^K / d), K = width(x) + ceil(log2 d).
	localparam int K10 = T10_W + 4;
	localparam int K5  = U_W + 3;
	localparam logic [63:0] M10_FULL = ((64'd1 << K10) + 64'd9) / 64'd10;
	localparam logic [63:0] M5_FULL  = ((64'd1 << K5) + 64'd4) / 64'd5;

	// Operand widths of the shared multiplier.
	localparam int MUL_A_W = (U_W > T10_W) ? U_W : T10_W;
	localparam int M10_W   = K10 - 3;
	localparam int M5_W    = K5 - 2;
	localparam int MB_1    = (M10_W > M5_W) ? M10_W : M5_W;
	localparam int MUL_B_W = (MB_1 > GAIN_W) ? MB_1 : GAIN_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	localparam logic [MUL_B_W-1:0] M10 = M10_FULL[MUL_B_W-1:0];
	localparam logic [MUL_B_W-1:0] M5  = M5_FULL[MUL_B_W-1:0];

	localparam logic [ENV_W-1:0]  ENV_MAX  = '1;
	localparam logic [BEAT_W-1:0] BEAT_MAX = '1;
	localparam logic [BEAT_W-1:0] ONE_Q    = BEAT_W'(1) << LEVEL_BITS;

	// Width of ten or twelve times a beat value.
	localparam int CMP_W = BEAT_W + 4;

	// Sequencer states.
	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] ST_IDLE   = 4'd0;
	localparam logic [ST_W-1:0] ST_SMOOTH = 4'd1;
	localparam logic [ST_W-1:0] ST_GAIN   = 4'd2;
	localparam logic [ST_W-1:0] ST_RECIP5 = 4'd3;
	localparam logic [ST_W-1:0] ST_STORE  = 4'd4;
	localparam logic [ST_W-1:0] ST_BEAT_A = 4'd5;
	localparam logic [ST_W-1:0] ST_BEAT_B = 4'd6;
	localparam logic [ST_W-1:0] ST_ONSET  = 4'd7;
	localparam logic [ST_W-1:0] ST_DECAY  = 4'd8;
	localparam logic [ST_W-1:0] ST_DONE   = 4'd9;

endpackage

>>> hdl/abed_if.sv
// Channel interfaces of the band envelope beat detector: frame input, result output and gain write.
interface abed_frame_if import abed_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [LEVEL_BITS-1:0] bass_level;
	logic [LEVEL_BITS-1:0] mid_level;
	logic [LEVEL_BITS-1:0] treble_level;

	modport source (output valid, output bass_level, output mid_level, output treble_level,
		input ready);
	modport sink (input valid, input bass_level, input mid_level, input treble_level,
		output ready);
endinterface

interface abed_result_if import abed_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ENV_W-1:0]  bass_response;
	logic [ENV_W-1:0]  mid_response;
	logic [ENV_W-1:0]  treble_response;
	logic [BEAT_W-1:0] beat_level;
	logic              beat_flag;

	modport source (output valid, output bass_response, output mid_response,
		output treble_response, output beat_level, output beat_flag, input ready);
	modport sink (input valid, input bass_response, input mid_response,
		input treble_response, input beat_level, input beat_flag, output ready);
endinterface

interface abed_cfg_if import abed_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [GAIN_W-1:0] amp_gain;

	modport source (output valid, output amp_gain, input ready);
	modport sink (input valid, input amp_gain, output ready);
endinterface

>>> hdl/audio_band_envelope_beat_detect_core.sv
// Band envelope follower with beat detector, built around one shared multiplier.
//
// Usage: a frame of bass, mid and treble levels (Q0.16) is offered on frame_in; it is taken
// in a transfer when valid and ready are both high. Ready is high only while the sequencer is
// idle and reset is released. Each frame yields exactly one result on result_out: the three
// smoothed and amplified band envelopes (Q8.16, saturating), the beat intensity (Q1.16) and
// the beat flag. The gain register is written through cfg, which is always ready outside
// reset; write it only while no frame is in flight. Reset value is 5120, which gives unity gain.
//
// All steps run through the single multiplier. Each band takes four steps (divide by
// ten, gain product, divide by five, store), the beat path up to four (no decay step after
// an onset), and one more step hands the result to the output register. A new frame is
// taken only once the sequencer is back in idle, so frames are never overlapped.
//
// Reset clears all envelopes, the beat intensity and flag, and any pending result.
// A result waits in the output register while the receiver stalls. The next frame may be
// taken meanwhile; it runs to its last step and then holds there until the waiting result
// has been taken, so no result is lost or overwritten.
module audio_band_envelope_beat_detect_core import abed_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	abed_cfg_if.sink      cfg,
	abed_frame_if.sink    frame_in,
	abed_result_if.source result_out
);

	logic [ST_W-1:0]       state_q;
	logic [BAND_W-1:0]     band_q;
	logic [GAIN_W-1:0]     gain_q;
	logic [LEVEL_BITS-1:0] lvl_q [NUM_BANDS];
	logic [ENV_W-1:0]      env_q [NUM_BANDS];
	logic [BEAT_W-1:0]     beat_env_q;
	logic                  beat_on_q;
	logic [PROD_W-1:0]     prod_q;

	logic                  out_vld_q;
	logic [ENV_W-1:0]      out_env_q [NUM_BANDS];
	logic [BEAT_W-1:0]     out_beat_q;
	logic                  out_flag_q;

	logic [MUL_A_W-1:0]    op_a;
	logic [MUL_B_W-1:0]    op_b;
	logic [PROD_W-1:0]     prod_d;
	logic [PROD_W-1:0]     shr10;
	logic [PROD_W-1:0]     shr5;
	logic [PROD_W-1:0]     rnd_gain;
	logic [MUL_A_W-1:0]    q10;
	logic [BEAT_W-1:0]     q10_beat;
	logic [ENV_W-1:0]      q5_sat;
	logic [CMP_W-1:0]      ten_n;
	logic [CMP_W-1:0]      ten_decay;
	logic                  onset;
	logic                  out_free;
	logic                  in_xfer;

	assign cfg.ready      = arst_n;
	assign frame_in.ready = arst_n && (state_q == ST_IDLE);
	assign in_xfer        = frame_in.valid && frame_in.ready;
	assign out_free       = !out_vld_q || result_out.ready;

	// Quotients taken from the registered product.
	assign shr10    = prod_q >> K10;
	assign shr5     = prod_q >> K5;
	assign rnd_gain = (prod_q + PROD_W'(GAIN_HALF)) >> GAIN_SHIFT;
	assign q10      = shr10[MUL_A_W-1:0];
	assign q10_beat = (shr10 > PROD_W'(BEAT_MAX)) ? BEAT_MAX : shr10[BEAT_W-1:0];
	assign q5_sat   = (shr5 > PROD_W'(ENV_MAX)) ? ENV_MAX : shr5[ENV_W-1:0];

	// An onset needs the new intensity above 0.2 and above 1.2 times the held value.
	assign ten_n     = CMP_W'(q10_beat) * CMP_W'(10);
	assign onset     = (ten_n > (CMP_W'(ONE_Q) << 1)) &&
		(ten_n > CMP_W'(beat_env_q) * CMP_W'(12));
	assign ten_decay = CMP_W'(q10_beat) * CMP_W'(10);

	// Operand selection for the shared multiplier.
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			ST_SMOOTH: begin
				// 9 * env + level + 5, then divided by ten.
				op_a = (MUL_A_W'(env_q[band_q]) << 3) + MUL_A_W'(env_q[band_q]) +
					MUL_A_W'(lvl_q[band_q]) + MUL_A_W'(5);
				op_b = M10;
			end
			ST_GAIN: begin
				op_a = q10;
				op_b = MUL_B_W'(gain_q);
			end
			ST_RECIP5: begin
				op_a = rnd_gain[MUL_A_W-1:0];
				op_b = M5;
			end
			ST_BEAT_A: begin
				// 84 * bass + 24 * mid + 50, divided by one hundred as two divides by ten.
				op_a = MUL_A_W'(lvl_q[0]) * MUL_A_W'(84) + MUL_A_W'(lvl_q[1]) * MUL_A_W'(24) +
					MUL_A_W'(50);
				op_b = M10;
			end
			ST_BEAT_B: begin
				op_a = q10;
				op_b = M10;
			end
			ST_ONSET: begin
				op_a = (MUL_A_W'(beat_env_q) << 3) + MUL_A_W'(beat_env_q) +
					MUL_A_W'(q10_beat) + MUL_A_W'(5);
				op_b = M10;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign prod_d = PROD_W'(op_a) * PROD_W'(op_b);

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			lvl_q[0] <= frame_in.bass_level;
			lvl_q[1] <= frame_in.mid_level;
			lvl_q[2] <= frame_in.treble_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg.valid && cfg.ready) begin
			gain_q <= cfg.amp_gain;
		end
	end

	// Sequencer and state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			band_q     <= '0;
			env_q[0]   <= '0;
			env_q[1]   <= '0;
			env_q[2]   <= '0;
			beat_env_q <= '0;
			beat_on_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						band_q  <= '0;
						state_q <= ST_SMOOTH;
					end
				end
				ST_SMOOTH: state_q <= ST_GAIN;
				ST_GAIN:   state_q <= ST_RECIP5;
				ST_RECIP5: state_q <= ST_STORE;
				ST_STORE: begin
					env_q[band_q] <= q5_sat;
					if (band_q == BAND_W'(NUM_BANDS - 1)) begin
						state_q <= ST_BEAT_A;
					end else begin
						band_q  <= band_q + BAND_W'(1);
						state_q <= ST_SMOOTH;
					end
				end
				ST_BEAT_A: state_q <= ST_BEAT_B;
				ST_BEAT_B: state_q <= ST_ONSET;
				ST_ONSET: begin
					if (onset) begin
						beat_env_q <= q10_beat;
						beat_on_q  <= 1'b1;
						state_q    <= ST_DONE;
					end else begin
						state_q <= ST_DECAY;
					end
				end
				ST_DECAY: begin
					beat_env_q <= q10_beat;
					if (ten_decay < CMP_W'(ONE_Q)) begin
						beat_on_q <= 1'b0;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_vld_q <= 1'b1;
		end else if (result_out.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_env_q[0] <= env_q[0];
			out_env_q[1] <= env_q[1];
			out_env_q[2] <= env_q[2];
			out_beat_q   <= beat_env_q;
			out_flag_q   <= beat_on_q;
		end
	end

	assign result_out.valid           = out_vld_q;
	assign result_out.bass_response   = out_env_q[0];
	assign result_out.mid_response    = out_env_q[1];
	assign result_out.treble_response = out_env_q[2];
	assign result_out.beat_level      = out_beat_q;
	assign result_out.beat_flag       = out_flag_q;

endmodule

>>> hdl/abed_chk.sv
// Port-level checker of the band envelope beat detector and its bind to the top level.
module abed_chk import abed_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [ENV_W-1:0]  bass_response,
	input logic [ENV_W-1:0]  mid_response,
	input logic [ENV_W-1:0]  treble_response,
	input logic [BEAT_W-1:0] beat_level,
	input logic              beat_flag
);

	// A frame keeps the block busy after its transfer, so the input is not ready again at once.
	a_busy_after_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted again right after a transfer");

	// A stalled result stays offered and unchanged.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
		$stable({bass_response, mid_response, treble_response, beat_level, beat_flag}))
		else $error("stalled result changed or vanished");

	// An active beat flag always comes with an intensity of at least 0.1.
	a_flag_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && beat_flag |->
		(CMP_W'(beat_level) * CMP_W'(10)) >= CMP_W'(ONE_Q))
		else $error("beat flag set with intensity below the release level");

endmodule

bind audio_band_envelope_beat_detect_core abed_chk u_abed_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (frame_in.valid),
	.in_ready        (frame_in.ready),
	.out_valid       (result_out.valid),
	.out_ready       (result_out.ready),
	.bass_response   (result_out.bass_response),
	.mid_response    (result_out.mid_response),
	.treble_response (result_out.treble_response),
	.beat_level      (result_out.beat_level),
	.beat_flag       (result_out.beat_flag)
);

>>> sim/testbench.sv
// Self-checking testbench for the band envelope beat detector core.
module testbench import abed_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// No transfer on any channel for this many cycles means the block has hung. The slowest
	// legal stretch is a long sender gap plus a long receiver stall plus the sequencer's work
	// on one frame, which stays far below this limit.
	localparam int STALL_LIMIT = 2000;

	// A frame and a result, laid out in the order of the channel payloads.
	typedef struct packed {
		logic [LEVEL_BITS-1:0] bass_level;
		logic [LEVEL_BITS-1:0] mid_level;
		logic [LEVEL_BITS-1:0] treble_level;
	} frame_t;

	typedef struct packed {
		logic [ENV_W-1:0]  bass_response;
		logic [ENV_W-1:0]  mid_response;
		logic [ENV_W-1:0]  treble_response;
		logic [BEAT_W-1:0] beat_level;
		logic              beat_flag;
	} result_t;

	// Keeps its own copy of the envelopes, the beat state and the gain. Every accepted frame
	// is run through the envelope and beat arithmetic, and the outcome waits in a queue until
	// the matching result comes out of the block.
	class beat_envelope_scoreboard;
		logic [GAIN_W-1:0] gain;
		logic [ENV_W-1:0]  bass_env;
		logic [ENV_W-1:0]  mid_env;
		logic [ENV_W-1:0]  treble_env;
		logic [BEAT_W-1:0] beat_env;
		logic              beat_on;
		result_t           pending_results[$];
		int                mismatches;

		function new();
			gain       = GAIN_RESET;
			bass_env   = '0;
			mid_env    = '0;
			treble_env = '0;
			beat_env   = '0;
			beat_on    = 1'b0;
			mismatches = 0;
		endfunction

		// Smooth toward the new level with factor 0.1, then scale by gain/5120 and saturate.
		// Both divisions round half up.
		function logic [ENV_W-1:0] smooth_amplify(logic [ENV_W-1:0] env,
			logic [LEVEL_BITS-1:0] level);
			bit [63:0] smoothed;
			bit [63:0] amplified;
			smoothed  = (64'd9 * env + level + 64'd5) / 64'd10;
			amplified = (smoothed * gain + 64'(GAIN_HALF)) / 64'(GAIN_RESET);
			return (amplified > 64'(ENV_MAX)) ? ENV_MAX : amplified[ENV_W-1:0];
		endfunction

		function void take_frame(frame_t f);
			bit [63:0] intensity;
			bit [63:0] held;
			result_t   r;
			bass_env   = smooth_amplify(bass_env, f.bass_level);
			mid_env    = smooth_amplify(mid_env, f.mid_level);
			treble_env = smooth_amplify(treble_env, f.treble_level);

			intensity = (64'd84 * f.bass_level + 64'd24 * f.mid_level + 64'd50) / 64'd100;
			if (intensity > 64'(BEAT_MAX))
				intensity = 64'(BEAT_MAX);

			// An onset needs the new intensity above 0.2 and above 1.2 times the held value;
			// otherwise the held value decays and the flag drops once it falls below 0.1.
			held = 64'(beat_env);
			if (64'd10 * intensity > 64'd2 * 64'(ONE_Q)
					&& 64'd10 * intensity > 64'd12 * held) begin
				beat_on = 1'b1;
				held    = intensity;
			end else begin
				held = (64'd9 * held + intensity + 64'd5) / 64'd10;
				if (held > 64'(BEAT_MAX))
					held = 64'(BEAT_MAX);
				if (64'd10 * held < 64'(ONE_Q))
					beat_on = 1'b0;
			end
			beat_env = held[BEAT_W-1:0];

			r.bass_response   = bass_env;
			r.mid_response    = mid_env;
			r.treble_response = treble_env;
			r.beat_level      = beat_env;
			r.beat_flag       = beat_on;
			pending_results.insert(pending_results.size(), r);
		endfunction

		function void report(string what, result_t want, result_t got);
			string want_s;
			string got_s;
			mismatches++;
			if (mismatches <= 10) begin
				want_s = $sformatf("expected bass %0d mid %0d treble %0d beat %0d flag %0d",
					want.bass_response, want.mid_response, want.treble_response,
					want.beat_level, want.beat_flag);
				got_s = $sformatf("got bass %0d mid %0d treble %0d beat %0d flag %0d",
					got.bass_response, got.mid_response, got.treble_response,
					got.beat_level, got.beat_flag);
				$display("%0t %s: %s, %s", $realtime, what, want_s, got_s);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				report("result with no frame outstanding", '0, got);
				return;
			end
			want = pending_results.pop_front();
			if (got.bass_response !== want.bass_response
					|| got.mid_response !== want.mid_response
					|| got.treble_response !== want.treble_response
					|| got.beat_level !== want.beat_level
					|| got.beat_flag !== want.beat_flag)
				report("result mismatch", want, got);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	// While this is set neither side of the block idles or stalls.
	bit steady = 1'b0;

	beat_envelope_scoreboard sb = new();

	abed_cfg_if    cfg_ch ();
	abed_frame_if  frame_ch ();
	abed_result_if result_ch ();

	audio_band_envelope_beat_detect_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_ch),
		.frame_in   (frame_ch),
		.result_out (result_ch)
	);

	always #6 clk = ~clk;

	// Offer one frame and return at the edge of its transfer. Before the frame goes out the
	// sender may hold back, mostly for single cycles and now and then for a long gap, so that
	// frames arrive at every point of the sequencer's work on the previous one.
	task automatic send_frame(input logic [LEVEL_BITS-1:0] bass,
		input logic [LEVEL_BITS-1:0] mid, input logic [LEVEL_BITS-1:0] treble);
		frame_t f;
		f = {bass, mid, treble};
		if (!steady && $urandom_range(0, 19) == 0) begin
			frame_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
		while (!steady && $urandom_range(0, 99) < 34) begin
			frame_ch.valid <= 1'b0;
			@(posedge clk);
		end
		frame_ch.valid        <= 1'b1;
		frame_ch.bass_level   <= bass;
		frame_ch.mid_level    <= mid;
		frame_ch.treble_level <= treble;
		@(posedge clk);
		while (!frame_ch.ready)
			@(posedge clk);
		sb.take_frame(f);
	endtask

	// Stop offering frames and wait until every outstanding result has been taken. Each frame
	// yields exactly one result, so the block is idle once the queue is empty.
	task automatic drain_results();
		frame_ch.valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Write the gain register; only called while the block is idle.
	task automatic write_gain(input logic [GAIN_W-1:0] gain);
		cfg_ch.valid    <= 1'b1;
		cfg_ch.amp_gain <= gain;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		sb.gain = gain;
		cfg_ch.valid <= 1'b0;
	endtask

	// Random frames shaped like music: runs of quiet frames let the held intensity decay and
	// the flag drop, short loud bursts cause onsets, and a fifth of all frames are plain noise
	// over the full range of every level.
	task automatic random_frames(input int count);
		int                    quiet_left;
		int                    burst_left;
		logic [LEVEL_BITS-1:0] bass;
		logic [LEVEL_BITS-1:0] mid;
		quiet_left = $urandom_range(1, 30);
		burst_left = 0;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 20) begin
				bass = LEVEL_BITS'($urandom);
				mid  = LEVEL_BITS'($urandom);
			end else if (quiet_left > 0) begin
				bass = LEVEL_BITS'($urandom_range(0, 6000));
				mid  = LEVEL_BITS'($urandom_range(0, 6000));
				quiet_left--;
				if (quiet_left == 0)
					burst_left = $urandom_range(1, 3);
			end else begin
				bass = LEVEL_BITS'($urandom_range(16000, 65535));
				mid  = LEVEL_BITS'($urandom);
				burst_left--;
				if (burst_left == 0)
					quiet_left = $urandom_range(1, 30);
			end
			send_frame(bass, mid, LEVEL_BITS'($urandom));
		end
	endtask

	// Receiver: check every result at the edge of its transfer, then pick the next ready
	// value. Ready drops on about a third of the cycles, with an occasional long stall.
	initial begin
		int      stall_left;
		result_t got;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				got = {result_ch.bass_response, result_ch.mid_response,
					result_ch.treble_response, result_ch.beat_level, result_ch.beat_flag};
				sb.check_result(got);
			end
			if (steady) begin
				result_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 49) == 0) begin
				stall_left = $urandom_range(5, 40);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= 34);
			end
		end
	end

	// Watchdog: ends the run if no transfer happens on any channel for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("testbench NOT OK");
		$finish;
	end

	// Main sequence: reset, a directed part over the extremes and thresholds, then random
	// phases, each under its own gain setting.
	initial begin
		logic [GAIN_W-1:0] gain;
		arst_n                <= 1'b0;
		cfg_ch.valid          <= 1'b0;
		cfg_ch.amp_gain       <= '0;
		frame_ch.valid        <= 1'b0;
		frame_ch.bass_level   <= '0;
		frame_ch.mid_level    <= '0;
		frame_ch.treble_level <= '0;
		result_ch.ready       <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Unity gain out of reset. Full scale on every band gives an onset; the same frame
		// again is not 1.2 times the held value, so the beat path decays instead.
		send_frame(16'h0000, 16'h0000, 16'h0000);
		send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_frame(16'hFFFF, 16'h0000, 16'h0000);
		send_frame(16'h0000, 16'hFFFF, 16'hFFFF);
		repeat (4) send_frame(16'h0000, 16'h0000, 16'h0000);
		// Intensity right at 0.2 and one step above it.
		send_frame(16'd15604, 16'h0000, 16'h0001);
		send_frame(16'd15605, 16'h0000, 16'h8000);
		send_frame(16'h5555, 16'hAAAA, 16'h5555);
		send_frame(16'hAAAA, 16'h5555, 16'hAAAA);

		// Zero gain clears every envelope on the next frame.
		drain_results();
		write_gain('0);
		send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_frame(16'h1234, 16'h5678, 16'h9ABC);

		// Largest gain drives the envelopes into saturation within a few frames.
		drain_results();
		write_gain('1);
		repeat (3) send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_frame(16'h0000, 16'h0000, 16'h0000);

		// Random phases: unity, shrinking, mildly growing, random and halving gains. The
		// fifth phase runs with both sides at full speed.
		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				1:       gain = 16'd4608;
				2:       gain = 16'd5632;
				3:       gain = GAIN_W'($urandom_range(0, 65535));
				5:       gain = 16'd2560;
				6:       gain = GAIN_W'($urandom_range(0, 65535));
				default: gain = GAIN_RESET;
			endcase
			drain_results();
			write_gain(gain);
			steady = (phase == 4);
			random_frames(200);
		end
		steady = 1'b0;

		// Let the last results drain, then watch a little longer for any stray result.
		drain_results();
		repeat (40) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
